FILE: rtl/core/ppid_pkg.sv
// Shared types and constants of the positional PID step unit.
package ppid_pkg;

    localparam int GAIN_W    = 16;
    localparam int SUM_W     = 32;
    localparam int PROD_W    = GAIN_W + SUM_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int DIVISOR_W = 15;
    localparam int LIMIT_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = LIMIT_W + 1;
    localparam int RECIP_W   = 32;
    localparam int RECIP_SHIFT = 38;

    localparam logic [DIVISOR_W-1:0] ERR_DIVISOR     = DIVISOR_W'(100);
    localparam logic [DIVISOR_W-1:0] SCALE_RESET     = DIVISOR_W'(1);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = LIMIT_W'(32767);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    // ceil(2^38 / 100); exact floor quotient for dividends below 2^32
    localparam logic [RECIP_W-1:0] RECIP_100 =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(ERR_DIVISOR) + 64'd1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_SCALE    = 3'd4,
        REG_LIMIT    = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR_MUL,
        ST_UPDATE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC_D,
        ST_OUT_DIV,
        ST_OUT_WAIT,
        ST_CLAMP
    } t_state;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_src;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic     load_meas;
        logic     err_mul;
        logic     div_start;
        logic     state_upd;
        logic     mul_en;
        t_mul_src mul_src;
        t_acc_op  acc_op;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/core/ppid_if.sv
// Handshake channel interfaces of the positional PID step unit.
interface ppid_meas_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface

interface ppid_drive_if #(
    parameter int DATA_WIDTH = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface ppid_cfg_if #(
    parameter int DATA_WIDTH = 16
) ();
    localparam int CFG_W = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;
    logic             valid;
    logic             ready;
    logic [2:0]       index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ppid_div.sv
// Restoring divider, one quotient bit per cycle.
module ppid_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 15
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [NUM_W-1:0]               i_num,
    input  logic [DEN_W-1:0]               i_den,
    input  logic [$clog2(NUM_W+1)-1:0]     i_steps,
    output logic                           o_busy,
    output logic [NUM_W-1:0]               o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_quot;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W:0]     trial;
    logic               qbit;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[NUM_W-2:0], qbit};
            if (qbit) begin
                r_rem <= DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DEN_W-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

FILE: rtl/core/ppid_ctrl.sv
// Sequencer of the positional PID step unit.
module ppid_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ppid_pkg::t_status i_status,
    output ppid_pkg::t_cmd   o_cmd
);
    import ppid_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_ERR_MUL;
            ST_ERR_MUL:  n_state = ST_UPDATE;
            ST_UPDATE:   n_state = ST_MUL_P;
            ST_MUL_P:    n_state = ST_MUL_I;
            ST_MUL_I:    n_state = ST_MUL_D;
            ST_MUL_D:    n_state = ST_ACC_D;
            ST_ACC_D:    n_state = ST_OUT_DIV;
            ST_OUT_DIV:  n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: if (!i_status.div_busy) n_state = ST_CLAMP;
            ST_CLAMP:    if (i_status.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.mul_src = MUL_P;
        o_cmd.acc_op  = ACC_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_meas = i_in_valid;
            end
            ST_ERR_MUL: o_cmd.err_mul = 1'b1;
            ST_UPDATE: o_cmd.state_upd = 1'b1;
            ST_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = MUL_P;
            end
            ST_MUL_I: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = MUL_I;
                o_cmd.acc_op  = ACC_LOAD;
            end
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = MUL_D;
                o_cmd.acc_op  = ACC_ADD;
            end
            ST_ACC_D: o_cmd.acc_op = ACC_ADD;
            ST_OUT_DIV: o_cmd.div_start = 1'b1;
            ST_CLAMP: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end
endmodule

FILE: rtl/core/ppid_dp.sv
// Datapath of the positional PID step unit: settings, error state, MAC, divide, clamp.
module ppid_dp #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [((DATA_WIDTH > 16) ? DATA_WIDTH : 16)-1:0] i_cfg_data,
    input  logic signed [DATA_WIDTH-1:0]      i_measurement,
    input  ppid_pkg::t_cmd                    i_cmd,
    output ppid_pkg::t_status                 o_status,
    output logic                              o_drive_valid,
    input  logic                              i_drive_ready,
    output logic signed [DATA_WIDTH-1:0]      o_drive
);
    import ppid_pkg::*;

    localparam int ERR_W   = DATA_WIDTH - 5;
    localparam int DIFF_W  = DATA_WIDTH + 1;
    localparam int CNT_W   = $clog2(ACC_W + 1);
    localparam int EPROD_W = DATA_WIDTH + RECIP_W;

    // settings
    logic signed [DATA_WIDTH-1:0] r_setpoint;
    logic signed [GAIN_W-1:0]     r_gain_p;
    logic signed [GAIN_W-1:0]     r_gain_i;
    logic signed [GAIN_W-1:0]     r_gain_d;
    logic [DIVISOR_W-1:0]         r_scale;
    logic [LIMIT_W-1:0]           r_limit;

    // loop state
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ERR_W-1:0]  r_last;
    logic signed [ERR_W-1:0]  r_prev;

    // per-item work registers
    logic signed [DIFF_W-1:0] r_diff;
    logic [EPROD_W-1:0]       r_err_prod;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W:0]    r_derr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_neg;
    logic                     r_out_valid;
    logic signed [DATA_WIDTH-1:0] r_drive;

    logic [DATA_WIDTH-1:0]    diff_mag;
    logic [ACC_W-1:0]         acc_mag;
    logic [DIVISOR_W-1:0]     div_den;
    logic                     div_busy;
    logic [ACC_W-1:0]         div_quot;
    logic signed [ERR_W-1:0]  err_q;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  mul_b;
    logic signed [GAIN_W-1:0] mul_a;
    logic [LIMIT_W-1:0]       lim_mag;
    logic signed [OUT_W-1:0]  clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_scale    <= SCALE_RESET;
            r_limit    <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_SETPOINT: r_setpoint <= i_cfg_data[DATA_WIDTH-1:0];
                REG_GAIN_P:   r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                REG_SCALE:    r_scale    <= i_cfg_data[DIVISOR_W-1:0];
                REG_LIMIT:    r_limit    <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // magnitudes and divider feed
    assign diff_mag = r_diff[DIFF_W-1] ? DATA_WIDTH'(-r_diff) : DATA_WIDTH'(r_diff);
    assign acc_mag  = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign div_den  = (r_scale == '0) ? SCALE_RESET : r_scale;

    ppid_div #(
        .NUM_W (ACC_W),
        .DEN_W (DIVISOR_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (acc_mag),
        .i_den   (div_den),
        .i_steps (CNT_W'(ACC_W)),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // error by reciprocal multiply, then saturating sum
    assign err_q    = ERR_W'(r_err_prod >> RECIP_SHIFT);
    assign n_err    = r_diff[DIFF_W-1] ? -err_q : err_q;
    assign sum_wide = (SUM_W+1)'(r_sum) + (SUM_W+1)'(n_err);

    always_comb begin
        unique case (sum_wide[SUM_W:SUM_W-1])
            2'b01:   n_sum = SUM_MAX;
            2'b10:   n_sum = SUM_MIN;
            default: n_sum = sum_wide[SUM_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
            r_prev <= '0;
        end else if (i_cmd.state_upd) begin
            r_sum  <= n_sum;
            r_prev <= r_last;
            r_last <= n_err;
        end
    end

    // multiply-accumulate
    always_comb begin
        unique case (i_cmd.mul_src)
            MUL_P: begin
                mul_a = r_gain_p;
                mul_b = SUM_W'(r_err);
            end
            MUL_I: begin
                mul_a = r_gain_i;
                mul_b = r_sum;
            end
            MUL_D: begin
                mul_a = r_gain_d;
                mul_b = SUM_W'(r_derr);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_meas) begin
            r_diff <= DIFF_W'(r_setpoint) - DIFF_W'(i_measurement);
        end
        if (i_cmd.err_mul) begin
            r_err_prod <= EPROD_W'(diff_mag) * EPROD_W'(RECIP_100);
        end
        if (i_cmd.state_upd) begin
            r_err  <= n_err;
            r_derr <= (ERR_W+1)'(r_last) - (ERR_W+1)'(r_prev);
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= ACC_W'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            default: ;
        endcase
        if (i_cmd.div_start) begin
            r_neg <= r_acc[ACC_W-1];
        end
    end

    // clamp and output register
    assign lim_mag = (div_quot > ACC_W'(r_limit)) ? r_limit : div_quot[LIMIT_W-1:0];
    assign clamped = r_neg ? -OUT_W'(lim_mag) : OUT_W'(lim_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_drive_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_drive <= DATA_WIDTH'(clamped);
        end
    end

    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || i_drive_ready;
    assign o_drive_valid     = r_out_valid;
    assign o_drive           = r_drive;
endmodule

FILE: rtl/core/positional_pid_step_unit.sv
// Positional PID step unit: one measurement item in, one drive item out.
//
// Channels: i_meas (sink) takes measurement items, o_drive (source) returns one
// drive item per measurement, i_cfg (sink) writes settings by index:
// 0 setpoint, 1 gain_p, 2 gain_i, 3 gain_d, 4 scale_divisor, 5 output_limit.
// i_cfg is always ready; write it only while no item is in flight.
// An item is moved when valid and ready are both high at a rising clock edge.
//
// Flow: one item is in work at a time. The error divide by 100 is a reciprocal
// multiply; the output divide runs in the one-bit-per-cycle divider, which
// shifts out 50 quotient bits. After accept the sequencer steps through error
// multiply, state update, the P, I and D multiplies, the last add, divide start,
// the divide wait and clamp; the next item is taken after the drive load.
// The drive item sits in an output register; a stalled receiver holds only the
// final load, the next item may already be accepted and worked on.
//
// Reset (synchronous, active low) clears the sum and error history, returns
// settings to gain 0, setpoint 0, divisor 1, limit 32767 and drops o_drive.valid.
module positional_pid_step_unit #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ppid_cfg_if.sink            i_cfg,
    ppid_meas_if.sink           i_meas,
    ppid_drive_if.source        o_drive
);
    import ppid_pkg::*;

    localparam int CFG_W = (DATA_WIDTH > 16) ? DATA_WIDTH : 16;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_cfg.ready  = 1'b1;
    assign i_meas.ready = in_ready;

    ppid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_meas.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ppid_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_idx     (i_cfg.index),
        .i_cfg_data    (CFG_W'(i_cfg.data)),
        .i_measurement (i_meas.measurement),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_drive_valid (o_drive.valid),
        .i_drive_ready (o_drive.ready),
        .o_drive       (o_drive.drive)
    );
endmodule

FILE: rtl/core/ppid_checker.sv
// Port-level checks of the positional PID step unit and their binding.
module ppid_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_meas_valid,
    input logic                  i_meas_ready,
    input logic                  i_drive_valid,
    input logic                  i_drive_ready,
    input logic [DATA_WIDTH-1:0] i_drive
);
    logic in_acc;

    assign in_acc = i_meas_valid && i_meas_ready;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_drive_valid)
        else $error("drive valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_drive_valid && !i_drive_ready |=> i_drive_valid && $stable(i_drive))
        else $error("stalled drive item changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_meas_ready)
        else $error("second item taken while one is in work");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> ##1 !$rose(i_drive_valid))
        else $error("drive item shown too soon after accept");
endmodule

bind positional_pid_step_unit ppid_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_ppid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_meas_valid  (i_meas.valid),
    .i_meas_ready  (i_meas.ready),
    .i_drive_valid (o_drive.valid),
    .i_drive_ready (o_drive.ready),
    .i_drive       (o_drive.drive)
);
